>>> src/vtn_pkg.sv
// Package with payload types, constants and helpers for the vector transform normalize unit.
`default_nettype none
package vtn_pkg;

  localparam int unsigned CoefW = 16;
  localparam int unsigned RowW = 48;
  localparam int unsigned ProdW = 32;
  localparam int unsigned SumW = 34;
  localparam int unsigned MagW = 33;
  localparam int unsigned NormW = 30;
  localparam int unsigned SqW = 62;
  localparam int unsigned RootW = 31;
  localparam int unsigned QW = 16;
  localparam int unsigned NumW = NormW + 14 + 1;
  localparam int unsigned ShW = 6;
  localparam logic [QW-1:0] OneQ14 = 16'd16384;

  localparam logic [1:0] CfgRow0 = 2'd0;
  localparam logic [1:0] CfgRow1 = 2'd1;
  localparam logic [1:0] CfgRow2 = 2'd2;

  typedef enum logic {
    CMD_FORWARD = 1'b0,
    CMD_INVERSE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               command;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic signed [15:0] z_in;
  } vtn_in_t;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic signed [15:0] z_out;
    logic               zero_length;
  } vtn_out_t;

  typedef logic signed [CoefW-1:0] coef3_t [3];

endpackage
`default_nettype wire

>>> src/vtn_sqrt_stage.sv
// One registered stage of a restoring square root, two result bits per stage, one when HasLow is clear.
`default_nettype none
module vtn_sqrt_stage
  import vtn_pkg::*;
#(
  parameter int unsigned STEP = 0,
  parameter int unsigned PASSW = 120
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             vld_i,
  input  wire logic [SqW-1:0]   rem_i,
  input  wire logic [RootW-1:0] root_i,
  input  wire logic [PASSW-1:0] pass_i,
  output logic                  vld_o,
  output logic [SqW-1:0]        rem_o,
  output logic [RootW-1:0]      root_o,
  output logic [PASSW-1:0]      pass_o
);

  localparam int unsigned B0 = 2 * (RootW - 1 - 2 * STEP);
  localparam bit HasLow = (B0 >= 2);
  localparam int unsigned B1 = HasLow ? B0 - 2 : 0;

  logic [SqW+1:0]   rem_a;
  logic [RootW-1:0] root_a;
  logic [SqW+1:0]   trial_a;
  logic [SqW+1:0]   rem_b;
  logic [RootW-1:0] root_b;
  logic [SqW+1:0]   trial_b;
  logic             vld_r;
  logic [SqW-1:0]   rem_r;
  logic [RootW-1:0] root_r;
  logic [PASSW-1:0] pass_r;

  // Root bit k decided by comparing with (2*root + (1 << k)) << k, root holding higher bits.
  always_comb begin
    trial_a = (({2'b0, SqW'(0)} | (SqW+2)'(root_i)) << (B0/2 + 1))
              | ((SqW+2)'(1) << B0);
    if ({2'b0, rem_i} >= trial_a) begin
      rem_a  = {2'b0, rem_i} - trial_a;
      root_a = root_i | (RootW'(1) << (B0/2));
    end else begin
      rem_a  = {2'b0, rem_i};
      root_a = root_i;
    end
    trial_b = ((SqW+2)'(root_a) << (B1/2 + 1)) | ((SqW+2)'(1) << B1);
    if (HasLow && rem_a >= trial_b) begin
      rem_b  = rem_a - trial_b;
      root_b = root_a | (RootW'(1) << (B1/2));
    end else begin
      rem_b  = rem_a;
      root_b = root_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    rem_r  <= rem_b[SqW-1:0];
    root_r <= root_b;
    pass_r <= pass_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pass_o = pass_r;

endmodule
`default_nettype wire

>>> src/vtn_div_stage.sv
// One registered stage of three parallel restoring dividers, one quotient bit each.
`default_nettype none
module vtn_div_stage
  import vtn_pkg::*;
#(
  parameter int unsigned PASSW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             vld_i,
  input  wire logic [NumW-1:0]  num_i [3],
  input  wire logic [RootW-1:0] den_i,
  input  wire logic [RootW:0]   rem_i [3],
  input  wire logic [QW-1:0]    q_i [3],
  input  wire logic [PASSW-1:0] pass_i,
  output logic                  vld_o,
  output logic [NumW-1:0]       num_o [3],
  output logic [RootW-1:0]      den_o,
  output logic [RootW:0]        rem_o [3],
  output logic [QW-1:0]         q_o [3],
  output logic [PASSW-1:0]      pass_o
);

  logic             vld_r;
  logic [NumW-1:0]  num_r [3];
  logic [RootW-1:0] den_r;
  logic [RootW:0]   rem_r [3];
  logic [QW-1:0]    q_r [3];
  logic [PASSW-1:0] pass_r;
  logic [RootW+1:0] sh [3];
  logic [RootW:0]   rem_nxt [3];
  logic [QW-1:0]    q_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh[k] = {rem_i[k], num_i[k][NumW-1]};
      if (sh[k] >= {2'b0, den_i}) begin
        rem_nxt[k] = (RootW+1)'(sh[k] - {2'b0, den_i});
        q_nxt[k]   = {q_i[k][QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[k][RootW:0];
        q_nxt[k]   = {q_i[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    for (int k = 0; k < 3; k++) begin
      num_r[k] <= {num_i[k][NumW-2:0], 1'b0};
      rem_r[k] <= rem_nxt[k];
      q_r[k]   <= q_nxt[k];
    end
    den_r  <= den_i;
    pass_r <= pass_i;
  end

  assign vld_o  = vld_r;
  assign num_o  = num_r;
  assign den_o  = den_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign pass_o = pass_r;

endmodule
`default_nettype wire

>>> src/vtn_front.sv
// Front pipeline: matrix multiply, magnitudes, normalizing shift and squared length.
`default_nettype none
module vtn_front
  import vtn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_i,
  input  wire vtn_in_t           in_i,
  input  wire logic [RowW-1:0]   row_i [3],
  output logic                   vld_o,
  output logic [SqW-1:0]         len2_o,
  output logic [NormW-1:0]       mag_o [3],
  output logic [2:0]             neg_o,
  output logic                   zero_o
);

  // Stage 1: nine products.
  logic                     s1_vld_r;
  logic signed [ProdW-1:0]  s1_prod_r [3][3];
  logic signed [CoefW-1:0]  cf [3][3];
  logic signed [CoefW-1:0]  vv [3];

  always_comb begin
    vv[0] = in_i.x_in;
    vv[1] = in_i.y_in;
    vv[2] = in_i.z_in;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd_t'(in_i.command) == CMD_INVERSE) begin
          cf[j][i] = row_i[j][CoefW*i +: CoefW];
        end else begin
          cf[j][i] = row_i[i][CoefW*j +: CoefW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_i;
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        s1_prod_r[j][i] <= cf[j][i] * vv[i];
      end
    end
  end

  // Stage 2: sums and magnitudes.
  logic                   s2_vld_r;
  logic [MagW-1:0]        s2_mag_r [3];
  logic [2:0]             s2_neg_r;
  logic signed [SumW-1:0] sum [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = SumW'(s1_prod_r[j][0]) + SumW'(s1_prod_r[j][1]) + SumW'(s1_prod_r[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    for (int j = 0; j < 3; j++) begin
      s2_neg_r[j] <= sum[j][SumW-1];
      s2_mag_r[j] <= sum[j][SumW-1] ? MagW'(-sum[j]) : MagW'(sum[j]);
    end
  end

  // Stage 3: leading one of the largest magnitude.
  logic            s3_vld_r;
  logic [MagW-1:0] s3_mag_r [3];
  logic [2:0]      s3_neg_r;
  logic [ShW-1:0]  s3_msb_r;
  logic            s3_zero_r;
  logic [MagW-1:0] orv;
  logic [ShW-1:0]  msb;

  always_comb begin
    orv = s2_mag_r[0] | s2_mag_r[1] | s2_mag_r[2];
    msb = '0;
    for (int b = 0; b < MagW; b++) begin
      if (orv[b]) begin
        msb = ShW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_mag_r  <= s2_mag_r;
    s3_neg_r  <= s2_neg_r;
    s3_msb_r  <= msb;
    s3_zero_r <= (orv == '0);
  end

  // Stage 4: shift so the leading one of the largest sits at bit 29.
  logic            s4_vld_r;
  logic [NormW-1:0] s4_mag_r [3];
  logic [2:0]      s4_neg_r;
  logic            s4_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    for (int j = 0; j < 3; j++) begin
      if (s3_msb_r >= ShW'(NormW - 1)) begin
        s4_mag_r[j] <= NormW'(s3_mag_r[j] >> (s3_msb_r - ShW'(NormW - 1)));
      end else begin
        s4_mag_r[j] <= NormW'(s3_mag_r[j] << (ShW'(NormW - 1) - s3_msb_r));
      end
    end
    s4_neg_r  <= s3_neg_r;
    s4_zero_r <= s3_zero_r;
  end

  // Stage 5: squares.
  logic             s5_vld_r;
  logic [SqW-1:0]   s5_sq_r [3];
  logic [NormW-1:0] s5_mag_r [3];
  logic [2:0]       s5_neg_r;
  logic             s5_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    for (int j = 0; j < 3; j++) begin
      s5_sq_r[j] <= SqW'(s4_mag_r[j]) * SqW'(s4_mag_r[j]);
    end
    s5_mag_r  <= s4_mag_r;
    s5_neg_r  <= s4_neg_r;
    s5_zero_r <= s4_zero_r;
  end

  // Stage 6: sum of squares.
  logic             s6_vld_r;
  logic [SqW-1:0]   s6_len_r;
  logic [NormW-1:0] s6_mag_r [3];
  logic [2:0]       s6_neg_r;
  logic             s6_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    s6_len_r  <= s5_sq_r[0] + s5_sq_r[1] + s5_sq_r[2];
    s6_mag_r  <= s5_mag_r;
    s6_neg_r  <= s5_neg_r;
    s6_zero_r <= s5_zero_r;
  end

  assign vld_o  = s6_vld_r;
  assign len2_o = s6_len_r;
  assign mag_o  = s6_mag_r;
  assign neg_o  = s6_neg_r;
  assign zero_o = s6_zero_r;

endmodule
`default_nettype wire

>>> src/vector_transform_normalize_unit.sv
// Top level of the vector transform normalize unit.
//
//  Channel | Ports                         | Transfer
//  input   | start, busy, in_data          | start high and busy low at a rising edge
//  result  | out_valid, out_data           | out_valid high for one cycle
//  config  | cfg_valid, cfg_ready, cfg_*   | cfg_valid and cfg_ready high
//
// One vector is taken every cycle; busy is always low after reset.
// The pipeline has 6 front stages, 16 root stages, 16 divide stages and 1 output stage.
// The square root is two bits per stage (one in its last stage) and the divide one quotient bit per stage.
// Reset is synchronous and clears the valid bits and the matrix to identity.
// The receiver cannot stall, so nothing in the pipeline ever holds.
`default_nettype none
module vector_transform_normalize_unit
  import vtn_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire vtn_in_t         in_data,
  output logic                 out_valid,
  output vtn_out_t             out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [RowW-1:0] cfg_data
);

  localparam int unsigned SqrtN = RootW / 2 + 1;
  localparam int unsigned DivN = QW;
  localparam int unsigned PassW = 3 * NumW + 3 + 1;

  logic [RowW-1:0] row_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= RowW'(64'h1000);
      row_r[1] <= RowW'(64'h1000_0000);
      row_r[2] <= RowW'(64'h1000_0000_0000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgRow0: row_r[0] <= cfg_data;
        CfgRow1: row_r[1] <= cfg_data;
        CfgRow2: row_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  logic             f_vld;
  logic [SqW-1:0]   f_len;
  logic [NormW-1:0] f_mag [3];
  logic [2:0]       f_neg;
  logic             f_zero;

  vtn_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (start && !busy),
    .in_i   (in_data),
    .row_i  (row_r),
    .vld_o  (f_vld),
    .len2_o (f_len),
    .mag_o  (f_mag),
    .neg_o  (f_neg),
    .zero_o (f_zero)
  );

  logic             sq_vld [SqrtN+1];
  logic [SqW-1:0]   sq_rem [SqrtN+1];
  logic [RootW-1:0] sq_root [SqrtN+1];
  logic [PassW-1:0] sq_pass [SqrtN+1];

  assign sq_vld[0]  = f_vld;
  assign sq_rem[0]  = f_len;
  assign sq_root[0] = '0;
  assign sq_pass[0] = {NumW'({f_mag[0], 14'd0}), NumW'({f_mag[1], 14'd0}),
                       NumW'({f_mag[2], 14'd0}), f_neg, f_zero};

  for (genvar g = 0; g < SqrtN; g++) begin : g_sqrt
    vtn_sqrt_stage #(.STEP(g), .PASSW(PassW)) u_st (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (sq_vld[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .pass_i (sq_pass[g]),
      .vld_o  (sq_vld[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .pass_o (sq_pass[g+1])
    );
  end

  // Numerators carry the rounding half-divisor so the divide stays plain.
  logic [RootW-1:0] s_root;
  logic [NumW-1:0]  num0 [3];
  logic [PassW-1:0] sp;

  assign s_root = sq_root[SqrtN];
  assign sp     = sq_pass[SqrtN];
  assign num0[0] = sp[PassW-1 -: NumW] + NumW'(s_root >> 1);
  assign num0[1] = sp[PassW-1-NumW -: NumW] + NumW'(s_root >> 1);
  assign num0[2] = sp[PassW-1-2*NumW -: NumW] + NumW'(s_root >> 1);

  // The quotient fits in 16 bits; pre-shift the upper numerator bits into the remainder.
  localparam int unsigned PreW = NumW - DivN;

  logic             dv_vld [DivN+1];
  logic [NumW-1:0]  dv_num [DivN+1][3];
  logic [RootW-1:0] dv_den [DivN+1];
  logic [RootW:0]   dv_rem [DivN+1][3];
  logic [QW-1:0]    dv_q [DivN+1][3];
  logic [3:0]       dv_pass [DivN+1];

  assign dv_vld[0]  = sq_vld[SqrtN];
  assign dv_den[0]  = s_root;
  assign dv_pass[0] = sp[3:0];
  for (genvar k = 0; k < 3; k++) begin : g_init
    assign dv_num[0][k] = num0[k] << PreW;
    assign dv_rem[0][k] = (RootW+1)'(num0[k] >> DivN);
    assign dv_q[0][k]   = '0;
  end

  for (genvar g = 0; g < DivN; g++) begin : g_div
    vtn_div_stage #(.PASSW(4)) u_st (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (dv_vld[g]),
      .num_i  (dv_num[g]),
      .den_i  (dv_den[g]),
      .rem_i  (dv_rem[g]),
      .q_i    (dv_q[g]),
      .pass_i (dv_pass[g]),
      .vld_o  (dv_vld[g+1]),
      .num_o  (dv_num[g+1]),
      .den_o  (dv_den[g+1]),
      .rem_o  (dv_rem[g+1]),
      .q_o    (dv_q[g+1]),
      .pass_o (dv_pass[g+1])
    );
  end

  logic       o_vld_r;
  vtn_out_t   o_data_r;
  logic [QW-1:0] qs [3];
  logic [QW-1:0] qo [3];
  logic [3:0]    fp;

  assign fp = dv_pass[DivN];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qs[k] = (dv_q[DivN][k] > OneQ14) ? OneQ14 : dv_q[DivN][k];
      if (fp[0]) begin
        qo[k] = '0;
      end else if (fp[k+1]) begin
        qo[k] = -qs[k];
      end else begin
        qo[k] = qs[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= dv_vld[DivN];
    end
    o_data_r.x_out       <= qo[0];
    o_data_r.y_out       <= qo[1];
    o_data_r.z_out       <= qo[2];
    o_data_r.zero_length <= fp[0];
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

`ifndef ASSERT_OFF
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_length |->
      out_data.x_out == '0 && out_data.y_out == '0 && out_data.z_out == '0)
    else $error("zero length result carries nonzero components");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_data.x_out) <= 16384 && $signed(out_data.x_out) >= -16384)
    else $error("x component out of range");
  a_sqrt_vld: assert property (@(posedge clk) disable iff (!rst_n)
    f_vld |=> sq_vld[1])
    else $error("valid bit lost in square root");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the vector transform normalize unit.
`default_nettype none
module tb;
  import vtn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  vtn_in_t in_data = '0;
  logic out_valid;
  vtn_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CfgRow0;
  logic [RowW-1:0] cfg_data = '0;

  logic [RowW-1:0] mat_rows [3];
  vtn_out_t norm_queue [$];
  int errors = 0;

  typedef struct {
    logic cfg;
    logic [1:0] idx;
    logic [RowW-1:0] row;
    vtn_in_t vec;
    logic typed;
    vtn_out_t want;
  } stim_row_t;

  vector_transform_normalize_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic signed [15:0] coef_at(input int row, input int col);
    return mat_rows[row][16*col +: 16];
  endfunction

  function automatic logic [31:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic vtn_out_t normalize_vec(input vtn_in_t v);
    vtn_out_t o;
    longint r [3];
    longint vi [3];
    logic [63:0] a [3];
    logic [63:0] mx, len2, s, q;
    vi[0] = v.x_in;
    vi[1] = v.y_in;
    vi[2] = v.z_in;
    for (int j = 0; j < 3; j++) begin
      r[j] = 0;
      for (int i = 0; i < 3; i++)
        r[j] += longint'(v.command == CMD_INVERSE ? coef_at(j, i) : coef_at(i, j)) * vi[i];
      a[j] = r[j] < 0 ? -r[j] : r[j];
    end
    mx = a[0];
    if (a[1] > mx) mx = a[1];
    if (a[2] > mx) mx = a[2];
    o = '0;
    if (mx == 0) begin
      o.zero_length = 1'b1;
      return o;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int j = 0; j < 3; j++) a[j] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int j = 0; j < 3; j++) a[j] <<= 1;
    end
    len2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    s = root64(len2);
    for (int j = 0; j < 3; j++) begin
      q = s != 0 ? ((a[j] << 14) + (s >> 1)) / s : 0;
      if (q > OneQ14) q = OneQ14;
      if (r[j] < 0) q = (64'h10000 - q) & 64'hFFFF;
      if (j == 0) o.x_out = q[15:0];
      else if (j == 1) o.y_out = q[15:0];
      else o.z_out = q[15:0];
    end
    return o;
  endfunction

  always @(posedge clk) begin
    vtn_out_t want;
    if (rst_n && out_valid) begin
      if (norm_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = norm_queue.pop_front();
        if (want !== out_data) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h, actual %h", want, out_data);
        end
      end
    end
  end

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return;
    start <= 1'b0;
    if (p < 95) idle_cycles($urandom_range(1, 3));
    else idle_cycles($urandom_range(5, 40));
  endtask

  task automatic write_row(input logic [1:0] idx, input logic [RowW-1:0] row);
    wait (norm_queue.size() == 0);
    idle_cycles(Latency);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= row;
    do @(posedge clk); while (!cfg_ready);
    mat_rows[idx] = row;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_vec(input vtn_in_t v, input logic typed, input vtn_out_t want);
    vtn_out_t pred;
    start <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (busy);
    pred = normalize_vec(v);
    if (typed && pred !== want) begin
      errors++;
      if (errors <= 10) $display("table row: expected %h, predicted %h", want, pred);
    end
    norm_queue.push_back(typed ? want : pred);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 3)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [RowW-1:0] rand_row();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic stim_row_t vrow(input cmd_t c, input logic [15:0] x, input logic [15:0] y,
                                     input logic [15:0] z, input logic typed,
                                     input vtn_out_t want);
    stim_row_t t;
    t = '{cfg: 1'b0, idx: CfgRow0, row: '0, vec: '{c, x, y, z}, typed: typed, want: want};
    return t;
  endfunction

  function automatic stim_row_t crow(input logic [1:0] idx, input logic [RowW-1:0] row);
    stim_row_t t;
    t = '{cfg: 1'b1, idx: idx, row: row, vec: '0, typed: 1'b0, want: '0};
    return t;
  endfunction

  initial begin
    stim_row_t table_rows [$];
    vtn_out_t none;
    vtn_in_t v;
    int count;
    none = '0;
    mat_rows[0] = 48'h1000;
    mat_rows[1] = 48'h1000 << 16;
    mat_rows[2] = 48'h1000 << 32;
    idle_cycles(10);
    rst_n <= 1'b1;
    @(posedge clk);

    table_rows.push_back(vrow(CMD_FORWARD, 0, 0, 0, 1, '{0, 0, 0, 1}));
    table_rows.push_back(vrow(CMD_FORWARD, 16'h1000, 0, 0, 1, '{16'd16384, 0, 0, 0}));
    table_rows.push_back(vrow(CMD_INVERSE, 0, 16'h8000, 0, 1, '{0, -16'sd16384, 0, 0}));
    table_rows.push_back(vrow(CMD_FORWARD, 0, 0, 16'h7FFF, 1, '{0, 0, 16'd16384, 0}));
    table_rows.push_back(vrow(CMD_INVERSE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, none));
    table_rows.push_back(vrow(CMD_FORWARD, 16'h8000, 16'h8000, 16'h8000, 0, none));
    table_rows.push_back(vrow(CMD_FORWARD, 16'h0001, 16'hFFFF, 16'h0001, 0, none));
    table_rows.push_back(crow(CfgRow0, 48'h0001_8000_7FFF));
    table_rows.push_back(crow(CfgRow1, 48'h7FFF_7FFF_8000));
    table_rows.push_back(crow(CfgRow2, 48'h8000_0000_FFFF));
    table_rows.push_back(vrow(CMD_FORWARD, 16'h7FFF, 16'h8000, 16'h1234, 0, none));
    table_rows.push_back(vrow(CMD_INVERSE, 16'h8000, 16'h7FFF, 16'hEDCB, 0, none));
    table_rows.push_back(vrow(CMD_INVERSE, 16'h0001, 0, 0, 0, none));
    table_rows.push_back(crow(CfgRow0, '0));
    table_rows.push_back(crow(CfgRow1, '0));
    table_rows.push_back(crow(CfgRow2, '0));
    table_rows.push_back(vrow(CMD_FORWARD, 16'h7FFF, 16'h8000, 16'h7FFF, 1, '{0, 0, 0, 1}));
    table_rows.push_back(vrow(CMD_INVERSE, 16'h1111, 16'h2222, 16'h3333, 1, '{0, 0, 0, 1}));
    table_rows.push_back(crow(CfgRow1, {48{1'b1}}));
    table_rows.push_back(vrow(CMD_FORWARD, 0, 16'h0001, 0, 0, none));
    table_rows.push_back(vrow(CMD_INVERSE, 0, 16'h0001, 0, 0, none));

    foreach (table_rows[k]) begin
      if (table_rows[k].cfg) begin
        start <= 1'b0;
        write_row(table_rows[k].idx, table_rows[k].row);
      end else begin
        send_vec(table_rows[k].vec, table_rows[k].typed, table_rows[k].want);
        random_gap();
      end
    end

    count = 0;
    while (count < 1550) begin
      if (count % 200 == 0) begin
        start <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          case (count / 200 % 4)
            0: write_row(i[1:0], rand_row());
            1: write_row(i[1:0], {48{1'b1}} ^ (i == 2 ? '0 : 48'h7FFF << (16 * i)));
            2: write_row(i[1:0], 48'h1000 << (16 * i));
            default: write_row(i[1:0], 48'($urandom_range(0, 1)) ? rand_row() : '0);
          endcase
        end
      end
      v.command = cmd_t'($urandom_range(0, 1));
      v.x_in = rand_coord();
      v.y_in = rand_coord();
      v.z_in = rand_coord();
      send_vec(v, 1'b0, none);
      count++;
      if (count % 300 < 100) begin
        random_gap();
      end else if ($urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b0;

    wait (norm_queue.size() == 0);
    idle_cycles(Latency);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
src/vtn_pkg.sv
src/vtn_sqrt_stage.sv
src/vtn_div_stage.sv
src/vtn_front.sv
src/vector_transform_normalize_unit.sv
tb/sv/tb.sv
